// ===== rtl/core/sbsp_pkg.sv =====
// Shared types and constants for the servo bus status packet parser.
// No dependencies; used by sbsp_parse and servo_bus_status_packet_parser.
`default_nettype none

package sbsp_pkg;

    // input command codes
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_TICK  = 2'd2
    } t_sbsp_op;

    // completion status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CHECKSUM = 2'd1,
        ST_TIMEOUT  = 2'd2,
        ST_LENGTH   = 2'd3
    } t_sbsp_status;

    // kind of result item
    typedef enum logic {
        KIND_PARAM  = 1'b0,
        KIND_FINISH = 1'b1
    } t_sbsp_kind;

    localparam int unsigned POS_W = 9;

    // byte positions inside a packet
    localparam logic [POS_W-1:0] POS_ID    = 9'd2;
    localparam logic [POS_W-1:0] POS_LEN   = 9'd3;
    localparam logic [POS_W-1:0] POS_ERR   = 9'd4;
    localparam logic [POS_W-1:0] POS_PARAM = 9'd5;

    // length field covers error byte and checksum besides the parameters
    localparam logic [7:0] LEN_OVERHEAD = 8'd2;
    localparam logic [POS_W-1:0] CHECK_OFFSET = 9'd3;

    localparam logic [7:0] TIMEOUT_RESET = 8'd10;

    // one result item
    typedef struct packed {
        t_sbsp_kind   kind;
        t_sbsp_status status;
        logic [7:0]   servo_id;
        logic [7:0]   servo_error;
        logic [7:0]   param_count;
        logic [7:0]   param_index;
        logic [7:0]   param_value;
    } t_sbsp_result;

    // parser status seen by the top level
    typedef struct packed {
        logic armed;
        logic res_valid;
    } t_sbsp_flags;

endpackage

`default_nettype wire

// ===== rtl/core/sbsp_parse.sv =====
// Packet state and combinational parse step for the servo bus status parser.
// Depends on sbsp_pkg.
`default_nettype none

module sbsp_parse (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_step,
    input  wire logic [1:0]           i_op,
    input  wire logic [7:0]           i_byte,
    input  wire logic [7:0]           i_timeout_ticks,
    output sbsp_pkg::t_sbsp_result    o_result,
    output sbsp_pkg::t_sbsp_flags     o_flags
);

    logic                        r_armed,   n_armed;
    logic [sbsp_pkg::POS_W-1:0]  r_pos,     n_pos;
    logic [7:0]                  r_len,     n_len;
    logic [7:0]                  r_sum,     n_sum;
    logic [7:0]                  r_id,      n_id;
    logic [7:0]                  r_err,     n_err;
    logic [7:0]                  r_ticks,   n_ticks;

    logic                        res_valid;
    sbsp_pkg::t_sbsp_result      res;
    sbsp_pkg::t_sbsp_op          op;
    logic [sbsp_pkg::POS_W-1:0]  check_pos;
    logic [7:0]                  count;
    logic [7:0]                  known_count;
    logic [7:0]                  tick_inc;
    logic [sbsp_pkg::POS_W-1:0]  idx_wide;

    assign op          = sbsp_pkg::t_sbsp_op'(i_op);
    assign check_pos   = {1'b0, r_len} + sbsp_pkg::CHECK_OFFSET;
    assign count       = r_len - sbsp_pkg::LEN_OVERHEAD;
    assign known_count = ((r_pos > sbsp_pkg::POS_LEN) && (r_len >= sbsp_pkg::LEN_OVERHEAD))
                         ? count : 8'd0;
    assign tick_inc    = r_ticks + 8'd1;
    assign idx_wide    = r_pos - sbsp_pkg::POS_PARAM;

    // next state and result for one command
    always_comb begin
        n_armed   = r_armed;
        n_pos     = r_pos;
        n_len     = r_len;
        n_sum     = r_sum;
        n_id      = r_id;
        n_err     = r_err;
        n_ticks   = r_ticks;
        res_valid = 1'b0;
        res.kind        = sbsp_pkg::KIND_PARAM;
        res.status      = sbsp_pkg::ST_OK;
        res.servo_id    = r_id;
        res.servo_error = r_err;
        res.param_count = 8'd0;
        res.param_index = 8'd0;
        res.param_value = 8'd0;

        unique case (op)
            sbsp_pkg::OP_START: begin
                n_armed = 1'b1;
                n_pos   = '0;
                n_len   = 8'd0;
                n_sum   = 8'd0;
                n_id    = 8'd0;
                n_err   = 8'd0;
                n_ticks = 8'd0;
            end
            sbsp_pkg::OP_TICK: begin
                if (r_armed) begin
                    n_ticks = tick_inc;
                    if (tick_inc >= i_timeout_ticks) begin
                        res_valid       = 1'b1;
                        res.kind        = sbsp_pkg::KIND_FINISH;
                        res.status      = sbsp_pkg::ST_TIMEOUT;
                        res.param_count = known_count;
                        n_armed         = 1'b0;
                    end
                end
            end
            sbsp_pkg::OP_BYTE: begin
                if (r_armed) begin
                    priority if (r_pos < sbsp_pkg::POS_ID) begin
                        // header bytes, taken unchecked
                        n_pos = r_pos + 9'd1;
                    end else if (r_pos == sbsp_pkg::POS_ID) begin
                        n_id  = i_byte;
                        n_sum = r_sum + i_byte;
                        n_pos = r_pos + 9'd1;
                    end else if (r_pos == sbsp_pkg::POS_LEN) begin
                        n_len = i_byte;
                        n_sum = r_sum + i_byte;
                        n_pos = r_pos + 9'd1;
                        if (i_byte < sbsp_pkg::LEN_OVERHEAD) begin
                            res_valid  = 1'b1;
                            res.kind   = sbsp_pkg::KIND_FINISH;
                            res.status = sbsp_pkg::ST_LENGTH;
                            n_armed    = 1'b0;
                        end
                    end else if (r_pos == sbsp_pkg::POS_ERR) begin
                        n_err = i_byte;
                        n_sum = r_sum + i_byte;
                        n_pos = r_pos + 9'd1;
                    end else if (r_pos < check_pos) begin
                        // parameter byte goes straight out
                        n_sum           = r_sum + i_byte;
                        n_pos           = r_pos + 9'd1;
                        res_valid       = 1'b1;
                        res.param_count = count;
                        res.param_index = idx_wide[7:0];
                        res.param_value = i_byte;
                    end else begin
                        // checksum byte closes the packet
                        res_valid       = 1'b1;
                        res.kind        = sbsp_pkg::KIND_FINISH;
                        res.status      = ((~r_sum) == i_byte) ? sbsp_pkg::ST_OK
                                                               : sbsp_pkg::ST_CHECKSUM;
                        res.param_count = count;
                        n_armed         = 1'b0;
                    end
                end
            end
            default: begin
                // unused code, no effect
            end
        endcase
    end

    // packet state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
            r_pos   <= '0;
            r_len   <= 8'd0;
            r_sum   <= 8'd0;
            r_id    <= 8'd0;
            r_err   <= 8'd0;
            r_ticks <= 8'd0;
        end else if (i_step) begin
            r_armed <= n_armed;
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_sum   <= n_sum;
            r_id    <= n_id;
            r_err   <= n_err;
            r_ticks <= n_ticks;
        end
    end

    assign o_result        = res;
    assign o_flags.armed     = r_armed;
    assign o_flags.res_valid = res_valid;

endmodule

`default_nettype wire

// ===== rtl/core/servo_bus_status_packet_parser.sv =====
// Top level of the servo bus status packet parser: stream ports, input and
// result registers, timeout register. Depends on sbsp_pkg and sbsp_parse.
`default_nettype none

// Takes start, byte and tick commands one transfer per clock and reports each
// parameter byte as it arrives, then one finish item with ok, checksum error,
// timeout or length error. A command is registered on entry, parsed by the
// combinational packet state logic and its result registered on exit. The
// sustained rate is one command per cycle; only a stalled result side slows
// it. Commands that give no result (start, header bytes, ticks before
// timeout) pass the parse stage without occupying the result register. The
// timeout register is written through its own channel, which is always ready.
module servo_bus_status_packet_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // command stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  wire logic [1:0]  i_s_tuser,   // [1:0] opcode
    // result stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [47:0]      o_m_tdata,   // [1:0] status, [9:2] servo_id,
                                          // [17:10] servo_error, [25:18] param_count,
                                          // [33:26] param_index, [41:34] param_value,
                                          // [47:42] zero
    output logic             o_m_tuser,   // [0] result_kind
    // timeout register write
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_data
);

    logic                    r_in_valid;
    logic [1:0]              r_in_op;
    logic [7:0]              r_in_byte;
    logic                    r_out_valid;
    sbsp_pkg::t_sbsp_result  r_out;
    logic [7:0]              r_timeout;

    logic                    advance;
    sbsp_pkg::t_sbsp_result  parse_res;
    sbsp_pkg::t_sbsp_flags   parse_flags;

    // parse when a command waits and the result register is free or draining
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_op   <= i_s_tuser;
            r_in_byte <= i_s_tdata;
        end
    end

    // timeout register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= sbsp_pkg::TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            r_timeout <= i_cfg_data;
        end
    end

    sbsp_parse u_parse (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (advance),
        .i_op            (r_in_op),
        .i_byte          (r_in_byte),
        .i_timeout_ticks (r_timeout),
        .o_result        (parse_res),
        .o_flags         (parse_flags)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= parse_flags.res_valid;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && parse_flags.res_valid) begin
            r_out <= parse_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tdata  = {6'd0, r_out.param_value, r_out.param_index, r_out.param_count,
                         r_out.servo_error, r_out.servo_id, r_out.status};

    // full input register behind a stalled result blocks new commands
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_m_tready) |-> !o_s_tready)
        else $error("input accepted while both stages are held");

    // a finish item always leaves the parser disarmed
    a_finish_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && parse_flags.res_valid && parse_res.kind == sbsp_pkg::KIND_FINISH)
        |=> !parse_flags.armed)
        else $error("parser still armed after finish item");

    // an emitted parameter lies inside the announced count
    a_param_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == sbsp_pkg::KIND_PARAM)
        |-> (r_out.param_index < r_out.param_count))
        else $error("parameter index beyond parameter count");

    // results only come out of a parse step taken while armed
    a_result_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && parse_flags.res_valid) |-> parse_flags.armed)
        else $error("result produced while idle");

endmodule

`default_nettype wire
